// File: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Operation and status codes, the request and result item types, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned DataW        = 32;
  localparam int unsigned OpW          = 3;
  localparam int unsigned StatusW      = 2;

  typedef enum logic [OpW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DUMP_FWD   = 3'd4,
    OP_DUMP_REV   = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] value_out;
    logic                    last;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic step;
  } deq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic dump_start;
    logic dump_last;
  } deq_sts_t;

endpackage

// File: sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl: controller of the double-ended queue
// Accepts items while idle and walks through a dump one value per cycle.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  deq_sts_t sts_i,
  output deq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.step   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = start;
        if (start && sts_i.dump_start) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        cmd_o.step = 1'b1;
        if (sts_i.dump_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp: datapath of the double-ended queue
// Ring store, front pointer, fill count, dump cursor and result registers.
// ----------------------------------------------------------------------------
module deq_dp import deq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  deq_cmd_t cmd_i,
  output deq_sts_t sts_o,
  output res_t     res_o,
  output logic     res_valid_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned SumW = IdxW + 1;
  localparam logic [SumW-1:0] DepthS = SumW'(DEPTH);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  // Ring position of base + offset, where both stay below the depth plus one.
  function automatic logic [IdxW-1:0] ring_add(logic [IdxW-1:0] base,
                                               logic [SumW-1:0] offset);
    logic [SumW-1:0] sum;
    sum = SumW'(base) + offset;
    if (sum >= DepthS) begin
      sum = sum - DepthS;
    end
    return sum[IdxW-1:0];
  endfunction

  function automatic logic [IdxW-1:0] ring_inc(logic [IdxW-1:0] pos);
    return (pos == LastIdx) ? '0 : pos + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] ring_dec(logic [IdxW-1:0] pos);
    return (pos == '0) ? LastIdx : pos - 1'b1;
  endfunction

  logic signed [DataW-1:0] mem [DEPTH];

  logic [IdxW-1:0]    front_q, front_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    cur_q, cur_d;
  logic [CntW-1:0]    left_q, left_d;
  logic               fwd_q, fwd_d;
  logic               single_q, single_d;
  logic [StatusW-1:0] status_q, status_d;
  logic signed [DataW-1:0] rd_data_q;

  logic            is_empty, is_full, is_dump;
  logic [IdxW-1:0] tail_pos, back_pos, prev_front, rd_addr, wr_addr;
  logic            wr_en;

  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == DepthC);
  assign is_dump    = (req_i.op == OP_DUMP_FWD) || (req_i.op == OP_DUMP_REV);
  assign tail_pos   = ring_add(front_q, SumW'(count_q));
  assign back_pos   = ring_add(front_q, SumW'(count_q - 1'b1));
  assign prev_front = ring_dec(front_q);

  assign sts_o.dump_start = is_dump && !is_empty;
  assign sts_o.dump_last  = (left_q == '0);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    cur_d    = cur_q;
    left_d   = left_q;
    fwd_d    = fwd_q;
    single_d = 1'b0;
    status_d = STATUS_OK;
    wr_en    = 1'b0;
    wr_addr  = tail_pos;
    rd_addr  = front_q;
    if (cmd_i.step) begin
      rd_addr = cur_q;
      cur_d   = fwd_q ? ring_inc(cur_q) : ring_dec(cur_q);
      left_d  = left_q - 1'b1;
    end else if (cmd_i.accept) begin
      priority case (req_i.op)
        OP_PUSH_BACK: begin
          single_d = 1'b1;
          if (is_full) begin
            status_d = STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        OP_PUSH_FRONT: begin
          single_d = 1'b1;
          wr_addr  = prev_front;
          if (is_full) begin
            status_d = STATUS_FULL;
          end else begin
            wr_en   = 1'b1;
            front_d = prev_front;
            count_d = count_q + 1'b1;
          end
        end
        OP_POP_BACK: begin
          single_d = 1'b1;
          if (is_empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        OP_POP_FRONT: begin
          single_d = 1'b1;
          if (is_empty) begin
            status_d = STATUS_EMPTY;
          end else begin
            front_d = ring_inc(front_q);
            count_d = count_q - 1'b1;
          end
        end
        OP_DUMP_FWD, OP_DUMP_REV: begin
          fwd_d = (req_i.op == OP_DUMP_FWD);
          if (is_empty) begin
            single_d = 1'b1;
            status_d = STATUS_EMPTY;
          end else begin
            // The first value is read now; the cursor points at the second.
            rd_addr = fwd_d ? front_q : back_pos;
            cur_d   = fwd_d ? ring_inc(front_q) : ring_dec(back_pos);
            left_d  = count_q - 1'b1;
          end
        end
        default: begin
          single_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= req_i.value_in;
    end
    rd_data_q <= mem[rd_addr];
    status_q  <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= '0;
      count_q  <= '0;
      cur_q    <= '0;
      left_q   <= '0;
      fwd_q    <= 1'b0;
      single_q <= 1'b0;
    end else begin
      front_q  <= front_d;
      count_q  <= count_d;
      cur_q    <= cur_d;
      left_q   <= left_d;
      fwd_q    <= fwd_d;
      single_q <= single_d;
    end
  end

  // A status item and a dump value never share a cycle.
  assign res_valid_o     = single_q || cmd_i.step;
  assign res_o.status    = single_q ? status_q : STATUS_OK;
  assign res_o.value_out = single_q ? '0 : rd_data_q;
  assign res_o.last      = single_q || (left_q == '0);

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("fill count above depth");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(single_q && cmd_i.step))
    else $error("status item and dump value in the same cycle");

  a_dump_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !wr_en)
    else $error("store written during a dump");

  a_dump_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (count_q == $past(count_q)))
    else $error("fill count changed during a dump");
`endif

endmodule

// File: sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue: double-ended queue of signed 32-bit values
// Ring store with push and pop at both ends and dumps in either direction.
//
//   channel   handshake                  payload
//   request   start high, busy low       req_i   (op, value_in)
//   result    res_valid_o, one cycle     res_o   (status, value_out, last)
//
// A push, a pop or an empty dump gives its result in the next cycle, and a
// new item may be accepted in that same cycle.
// A dump of N values holds busy while it delivers them one value per cycle
// from the single read port of the ring store, the last one marked.
// After reset the queue is empty. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output res_t res_o,
  output logic res_valid_o
);

  deq_cmd_t cmd;
  deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  deq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

// File: bench/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb: self-checking bench for the double-ended queue
// Feeds push, pop and dump items through the start/busy handshake in random
// bursts and checks every result against a ring-store predictor kept in step
// with the accepted items.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import deq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH        = 16;
  localparam int          RANDOM_ITEMS = 125;
  localparam int          DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int          CYCLE_LIMIT  = 50000;

  // Codes outside the operation set; the block must ignore them.
  localparam logic [OpW-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE_7 = 3'd7;

  typedef enum int {PH_FILL, PH_MIXED, PH_DRAIN} phase_e;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic start       = 1'b0;
  req_t req_i       = '0;
  logic busy;
  res_t res_o;
  logic res_valid_o;

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Predicted queue contents.
  logic signed [DataW-1:0] store_mem [DEPTH];
  int unsigned head_pos   = 0;
  int unsigned fill_level = 0;

  req_t pending_reqs[$];
  res_t expected_results[$];

  int errors          = 0;
  int items_accepted  = 0;
  int ignored_items   = 0;
  int results_checked = 0;
  int dump_values     = 0;
  int full_refusals   = 0;
  int empty_answers   = 0;
  int peak_fill       = 0;
  int cycle_count     = 0;

  function void add_item(logic [OpW-1:0] op, logic signed [DataW-1:0] value);
    req_t r;
    r.op       = op;
    r.value_in = value;
    pending_reqs.push_back(r);
  endfunction

  function void queue_result(status_e status, logic signed [DataW-1:0] value,
                             logic last);
    res_t e;
    e.status    = status;
    e.value_out = value;
    e.last      = last;
    expected_results.push_back(e);
    if (status == STATUS_FULL) full_refusals++;
    if (status == STATUS_EMPTY) empty_answers++;
  endfunction

  function void apply_request(req_t r);
    int unsigned offset;
    case (r.op)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (fill_level == DEPTH) begin
          queue_result(STATUS_FULL, '0, 1'b1);
        end else begin
          if (r.op == OP_PUSH_BACK) begin
            store_mem[(head_pos + fill_level) % DEPTH] = r.value_in;
          end else begin
            head_pos = (head_pos + DEPTH - 1) % DEPTH;
            store_mem[head_pos] = r.value_in;
          end
          fill_level++;
          if (fill_level > peak_fill) peak_fill = fill_level;
          queue_result(STATUS_OK, '0, 1'b1);
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (fill_level == 0) begin
          queue_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          if (r.op == OP_POP_FRONT) head_pos = (head_pos + 1) % DEPTH;
          fill_level--;
          queue_result(STATUS_OK, '0, 1'b1);
        end
      end
      OP_DUMP_FWD, OP_DUMP_REV: begin
        if (fill_level == 0) begin
          queue_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < fill_level; i++) begin
            offset = (r.op == OP_DUMP_FWD) ? i : fill_level - 1 - i;
            queue_result(STATUS_OK, store_mem[(head_pos + offset) % DEPTH],
                         i + 1 == fill_level);
            dump_values++;
          end
        end
      end
      default: ignored_items++;
    endcase
  endfunction

  // Driver: bursts of items separated by random gaps; an item stays on the
  // request port until it is taken.
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      if (start && !busy) begin
        apply_request(req_i);
        void'(pending_reqs.pop_front());
        items_accepted++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          start <= 1'b1;
          req_i <= pending_reqs[0];
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(12, 1);
            gap_left   = $urandom_range(1) ? 0 : $urandom_range(5, 1);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task report_mismatch(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want,
             got);
    errors++;
  endtask

  always @(posedge clk_i) begin : monitor
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d value %0d last %0d",
                 $realtime, res_o.status, res_o.value_out, res_o.last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (res_o.status !== want.status)
          report_mismatch("status", want.status, res_o.status);
        if (res_o.value_out !== want.value_out)
          report_mismatch("value_out", want.value_out, res_o.value_out);
        if (res_o.last !== want.last)
          report_mismatch("last", want.last, res_o.last);
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d items pending, %0d results outstanding",
               $realtime, cycle_count, pending_reqs.size(), expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int     counted;
    int     pick;
    int     phase_len;
    int     sel;
    int     lim_push;
    int     lim_pop;
    int     lim_dump;
    phase_e phase;
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] value;

    // Empty queue: every pop and dump answers empty.
    add_item(OP_POP_BACK, 32'sd5);
    add_item(OP_POP_FRONT, -32'sd5);
    add_item(OP_DUMP_FWD, '0);
    add_item(OP_DUMP_REV, '1);
    // Extreme values through both ends, then both dump orders.
    add_item(OP_PUSH_BACK, 32'sh8000_0000);
    add_item(OP_PUSH_FRONT, 32'sh7fff_ffff);
    add_item(OP_PUSH_BACK, 32'sd0);
    add_item(OP_PUSH_FRONT, -32'sd1);
    add_item(OP_DUMP_FWD, 32'sh5555_5555);
    add_item(OP_DUMP_REV, 32'shaaaa_aaaa);
    add_item(OP_SPARE_6, 32'sh1234_5678);
    add_item(OP_SPARE_7, -32'sd1);
    add_item(OP_DUMP_FWD, '0);
    // Drain down to the last value, which is popped on its own.
    add_item(OP_POP_FRONT, '0);
    add_item(OP_POP_BACK, '0);
    add_item(OP_POP_FRONT, '0);
    add_item(OP_DUMP_REV, '0);
    add_item(OP_POP_BACK, '0);
    add_item(OP_DUMP_REV, '0);

    // Random part in phases that lean toward filling, mixing or draining, so
    // that the full and empty boundaries are both hit repeatedly.
    counted = 0;
    phase   = PH_FILL;
    while (counted < RANDOM_ITEMS) begin
      phase_len = $urandom_range(30, 18);
      if (phase_len > RANDOM_ITEMS - counted) phase_len = RANDOM_ITEMS - counted;
      case (phase)
        PH_FILL: begin
          lim_push = 75; lim_pop = 82; lim_dump = 95;
        end
        PH_MIXED: begin
          lim_push = 40; lim_pop = 70; lim_dump = 94;
        end
        default: begin
          lim_push = 10; lim_pop = 75; lim_dump = 94;
        end
      endcase
      repeat (phase_len) begin
        pick = $urandom_range(99);
        if (pick < lim_push) op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (pick < lim_pop) op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
        else if (pick < lim_dump) op = $urandom_range(1) ? OP_DUMP_FWD : OP_DUMP_REV;
        else op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        sel = $urandom_range(7);
        if (sel == 0) value = 32'sh8000_0000;
        else if (sel == 1) value = 32'sh7fff_ffff;
        else if (sel == 2) value = '0;
        else value = $urandom();
        add_item(op, value);
        if (op != OP_SPARE_6 && op != OP_SPARE_7) counted++;
      end
      case (phase)
        PH_FILL:  phase = PH_MIXED;
        PH_MIXED: phase = PH_DRAIN;
        default:  phase = PH_FILL;
      endcase
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime,
               expected_results.size());
      errors += expected_results.size();
    end

    $display("Covered %0d items (%0d with unused codes), %0d results checked, %0d dump values.",
             items_accepted, ignored_items, results_checked, dump_values);
    $display("Saw %0d full refusals and %0d empty answers; peak fill %0d of %0d, %0d errors.",
             full_refusals, empty_answers, peak_fill, DEPTH, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/deq_pkg.sv
sv/deq_ctrl.sv
sv/deq_dp.sv
sv/double_ended_queue.sv
bench/double_ended_queue_tb.sv
